[rtl/mie_pkg.sv]
package mie_pkg;

   localparam int unsigned DATA_BYTES_DEF = 16384;
   localparam int unsigned XLEN           = 32;
   localparam int unsigned REG_COUNT      = 32;
   localparam int unsigned REG_IDX_W      = 5;
   localparam int unsigned BANKS          = 4;
   localparam int unsigned CSR_IDX_W      = 1;

   localparam logic [XLEN-1:0] DATA_BASE_RST = 32'h2000_0000;
   localparam logic [XLEN-1:0] START_PC_RST  = 32'h1000_0000;

   localparam logic [CSR_IDX_W-1:0] CSR_DATA_BASE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_PC  = 1'b1;

   localparam logic [5:0] OP_REGIMM = 6'h01;
   localparam logic [5:0] OP_BEQ    = 6'h04;
   localparam logic [5:0] OP_BNE    = 6'h05;
   localparam logic [5:0] OP_BLEZ   = 6'h06;
   localparam logic [5:0] OP_BGTZ   = 6'h07;
   localparam logic [5:0] OP_ADDI   = 6'h08;
   localparam logic [5:0] OP_ADDIU  = 6'h09;
   localparam logic [5:0] OP_SLTI   = 6'h0A;
   localparam logic [5:0] OP_SLTIU  = 6'h0B;
   localparam logic [5:0] OP_ANDI   = 6'h0C;
   localparam logic [5:0] OP_ORI    = 6'h0D;
   localparam logic [5:0] OP_XORI   = 6'h0E;
   localparam logic [5:0] OP_LUI    = 6'h0F;
   localparam logic [5:0] OP_LB     = 6'h20;
   localparam logic [5:0] OP_LH     = 6'h21;
   localparam logic [5:0] OP_LWL    = 6'h22;
   localparam logic [5:0] OP_LW     = 6'h23;
   localparam logic [5:0] OP_LBU    = 6'h24;
   localparam logic [5:0] OP_LHU    = 6'h25;
   localparam logic [5:0] OP_LWR    = 6'h26;
   localparam logic [5:0] OP_SB     = 6'h28;
   localparam logic [5:0] OP_SH     = 6'h29;
   localparam logic [5:0] OP_SW     = 6'h2B;

   localparam logic [4:0] RI_BLTZ   = 5'h00;
   localparam logic [4:0] RI_BGEZ   = 5'h01;
   localparam logic [4:0] RI_BLTZAL = 5'h10;
   localparam logic [4:0] RI_BGEZAL = 5'h11;

   localparam logic [REG_IDX_W-1:0] LINK_REG = 5'd31;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_OVF  = 2'd1;
   localparam logic [1:0] ST_ADDR = 2'd2;
   localparam logic [1:0] ST_UNK  = 2'd3;

   typedef struct packed {
      logic                 en;
      logic [REG_IDX_W-1:0] idx;
      logic [XLEN-1:0]      data;
   } mie_rf_wr_type;

   function automatic logic [XLEN-1:0] sext16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

endpackage

[rtl/mie_if.sv]
interface mie_req_if;
   logic        valid;
   logic        ready;
   logic [5:0]  func;
   logic [4:0]  base_reg;
   logic [4:0]  target_reg;
   logic [15:0] immediate;

   modport source (output valid, output func, output base_reg, output target_reg,
                   output immediate, input ready);
   modport sink   (input valid, input func, input base_reg, input target_reg,
                   input immediate, output ready);
endinterface

interface mie_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] next_pc;
   logic [1:0]  status;
   logic        write_enable;
   logic [4:0]  write_index;
   logic [31:0] write_value;

   modport source (output valid, output next_pc, output status, output write_enable,
                   output write_index, output write_value, input ready);
   modport sink   (input valid, input next_pc, input status, input write_enable,
                   input write_index, input write_value, output ready);
endinterface

[rtl/mips_itype_execute_unit.sv]
// Executes one decoded I-type instruction per transfer against a 32-entry register file, a
// big-endian byte data window of DATA_BYTES bytes at data_base, and the program counter, and
// returns one result per instruction in order. The sustained rate is one instruction per cycle
// while rsp_bus is ready and no load-use wait occurs, passing register read, execute and data
// memory read, and write-back into the output register. An instruction that reads the target
// of the load just ahead of it waits in execute until that load leaves write-back, since load
// data arrives from the synchronous data memory only in the write-back stage. The data memory
// is four byte banks so that unaligned LWL and LWR reach four consecutive bytes in one access.
// After reset the data memory is cleared, during which no instruction is taken; configuration
// writes are taken at any time, and a write of start_pc also loads the program counter.
module mips_itype_execute_unit
   import mie_pkg::*;
#(
   parameter int unsigned DATA_BYTES = DATA_BYTES_DEF
)(
   input  logic                 clock,
   input  logic                 reset,
   mie_req_if.sink              req_bus,
   mie_rsp_if.source            rsp_bus,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [XLEN-1:0]      csr_wdata
);

   localparam int unsigned ROWS  = (DATA_BYTES + BANKS - 1) / BANKS;
   localparam int unsigned ROW_W = $clog2(ROWS);

   logic [XLEN-1:0] data_base_ff;
   logic [XLEN-1:0] pc_ff;

   logic                 s1_vld_ff;
   logic [5:0]           s1_op_ff;
   logic [REG_IDX_W-1:0] s1_rs_ff;
   logic [REG_IDX_W-1:0] s1_rt_ff;
   logic [15:0]          s1_imm_ff;
   logic [XLEN-1:0]      s1_seb_ff;

   logic                 s2_vld_ff;
   logic [XLEN-1:0]      s2_npc_ff;
   logic [1:0]           s2_status_ff;
   logic                 s2_wen_ff;
   logic [REG_IDX_W-1:0] s2_widx_ff;
   logic [XLEN-1:0]      s2_wval_ff;
   logic                 s2_load_ff;
   logic [5:0]           s2_op_ff;
   logic [1:0]           s2_k_ff;
   logic [1:0]           s2_r_ff;
   logic [XLEN-1:0]      s2_t_ff;
   logic [BANKS-1:0]     s2_st_en_ff;
   logic [ROW_W-1:0]     s2_row_ff    [BANKS];
   logic [7:0]           s2_st_dat_ff [BANKS];

   logic                 out_vld_ff;
   logic [XLEN-1:0]      out_npc_ff;
   logic [1:0]           out_status_ff;
   logic                 out_wen_ff;
   logic [REG_IDX_W-1:0] out_widx_ff;
   logic [XLEN-1:0]      out_wval_ff;

   logic out_free;
   logic s2_go;
   logic s2_free;
   logic hazard;
   logic s1_go;
   logic s1_free;
   logic req_acc;
   logic dm_busy;

   logic [REG_IDX_W-1:0] rf_idx_a;
   logic [REG_IDX_W-1:0] rf_idx_b;
   logic [XLEN-1:0]      rf_rd_a;
   logic [XLEN-1:0]      rf_rd_b;
   mie_rf_wr_type        rf_wr;

   logic [ROW_W-1:0] dm_rd_row  [BANKS];
   logic [7:0]       dm_rd      [BANKS];
   logic [BANKS-1:0] dm_wr_en;
   logic [ROW_W-1:0] ex_row     [BANKS];
   logic [7:0]       ex_st_dat  [BANKS];
   logic [BANKS-1:0] ex_st_en;
   logic [7:0]       ld_byte    [BANKS];

   logic [XLEN-1:0]      se;
   logic [XLEN-1:0]      zi;
   logic [XLEN-1:0]      s_val;
   logic [XLEN-1:0]      t_val;
   logic [XLEN-1:0]      sum;
   logic [XLEN-1:0]      off;
   logic                 ovf;
   logic [1:0]           k;
   logic [XLEN-1:0]      npc_seq;
   logic [XLEN-1:0]      link;
   logic [XLEN-1:0]      btarget;
   logic                 neg;
   logic                 zero;
   logic [2:0]           acc_n;
   logic                 acc_align;
   logic [XLEN-1:0]      acc_start;
   logic [1:0]           acc_r;
   logic [ROW_W-1:0]     row_base;
   logic                 in_win;
   logic                 acc_ok;
   logic                 take;
   logic                 wen;
   logic [REG_IDX_W-1:0] widx;
   logic [XLEN-1:0]      wval;
   logic [1:0]           status;
   logic                 is_load;
   logic                 is_store;
   logic [XLEN-1:0]      npc;

   logic [XLEN-1:0] ld_word;
   logic [XLEN-1:0] ld_val;
   logic [XLEN-1:0] wb_val;

   // Pipeline handshakes.
   assign out_free = !out_vld_ff || rsp_bus.ready;
   assign s2_go    = s2_vld_ff && out_free;
   assign s2_free  = !s2_vld_ff || s2_go;
   assign hazard   = s2_vld_ff && s2_load_ff && s2_wen_ff &&
                     ((s2_widx_ff == s1_rs_ff) || (s2_widx_ff == s1_rt_ff));
   assign s1_go    = s1_vld_ff && s2_free && !hazard;
   assign s1_free  = !s1_vld_ff || s1_go;
   assign req_bus.ready = !dm_busy && s1_free;
   assign req_acc  = req_bus.valid && req_bus.ready;

   // The register file is read again every cycle for a waiting instruction.
   assign rf_idx_a = req_acc ? req_bus.base_reg   : s1_rs_ff;
   assign rf_idx_b = req_acc ? req_bus.target_reg : s1_rt_ff;

   mie_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_idx_a  (rf_idx_a),
      .rd_idx_b  (rf_idx_b),
      .rd_data_a (rf_rd_a),
      .rd_data_b (rf_rd_b),
      .wr        (rf_wr)
   );

   mie_dmem #(
      .DATA_BYTES (DATA_BYTES)
   ) u_dmem (
      .clock   (clock),
      .reset   (reset),
      .busy    (dm_busy),
      .rd_row  (dm_rd_row),
      .rd_data (dm_rd),
      .wr_en   (dm_wr_en),
      .wr_row  (s2_row_ff),
      .wr_data (s2_st_dat_ff)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         data_base_ff <= DATA_BASE_RST;
         pc_ff        <= START_PC_RST;
      end else begin
         if (csr_we && (csr_index == CSR_DATA_BASE)) begin
            data_base_ff <= csr_wdata;
         end
         if (csr_we && (csr_index == CSR_START_PC)) begin
            pc_ff <= csr_wdata;
         end else if (s1_go) begin
            pc_ff <= npc;
         end
      end
   end

   // Execute stage: operands come from the register file or from the ALU result ahead.
   assign se    = sext16(s1_imm_ff);
   assign zi    = {16'h0000, s1_imm_ff};
   assign s_val = (s2_vld_ff && s2_wen_ff && !s2_load_ff && (s2_widx_ff == s1_rs_ff)) ?
                  s2_wval_ff : rf_rd_a;
   assign t_val = (s2_vld_ff && s2_wen_ff && !s2_load_ff && (s2_widx_ff == s1_rt_ff)) ?
                  s2_wval_ff : rf_rd_b;
   assign sum     = s_val + se;
   assign off     = s_val + s1_seb_ff;
   assign ovf     = !(s_val[31] ^ se[31]) && (s_val[31] ^ sum[31]);
   assign k       = sum[1:0];
   assign npc_seq = pc_ff + 32'd4;
   assign link    = pc_ff + 32'd8;
   assign btarget = npc_seq + {se[29:0], 2'b00};
   assign neg     = s_val[31];
   assign zero    = (s_val == '0);

   always_comb begin
      acc_n     = 3'd1;
      acc_align = 1'b1;
      acc_start = off;
      case (s1_op_ff)
         OP_LH, OP_LHU, OP_SH: begin
            acc_n     = 3'd2;
            acc_align = !sum[0];
         end
         OP_LW, OP_SW: begin
            acc_n     = 3'd4;
            acc_align = (sum[1:0] == 2'b00);
         end
         OP_LWL: begin
            acc_n = 3'd4 - {1'b0, k};
         end
         OP_LWR: begin
            acc_n     = {1'b0, k} + 3'd1;
            acc_start = off - {30'b0, k};
         end
         default: begin
            acc_n = 3'd1;
         end
      endcase
   end

   assign in_win   = ({1'b0, acc_start} + {30'b0, acc_n}) <= 33'(DATA_BYTES);
   assign acc_ok   = acc_align && in_win;
   assign acc_r    = acc_start[1:0];
   assign row_base = acc_start[ROW_W+1:2];

   always_comb begin
      take     = 1'b0;
      wen      = 1'b0;
      widx     = s1_rt_ff;
      wval     = '0;
      status   = ST_OK;
      is_load  = 1'b0;
      is_store = 1'b0;
      case (s1_op_ff)
         OP_ADDI: begin
            if (ovf) begin
               status = ST_OVF;
            end else begin
               wen  = 1'b1;
               wval = sum;
            end
         end
         OP_ADDIU: begin
            wen  = 1'b1;
            wval = sum;
         end
         OP_SLTI: begin
            wen  = 1'b1;
            wval = {31'b0, ($signed(s_val) < $signed(se))};
         end
         OP_SLTIU: begin
            wen  = 1'b1;
            wval = {31'b0, (s_val < se)};
         end
         OP_ANDI: begin
            wen  = 1'b1;
            wval = s_val & zi;
         end
         OP_ORI: begin
            wen  = 1'b1;
            wval = s_val | zi;
         end
         OP_XORI: begin
            wen  = 1'b1;
            wval = s_val ^ zi;
         end
         OP_LUI: begin
            wen  = 1'b1;
            wval = {s1_imm_ff, 16'h0000};
         end
         OP_BEQ: begin
            take = (s_val == t_val);
         end
         OP_BNE: begin
            take = (s_val != t_val);
         end
         OP_BLEZ: begin
            take = zero || neg;
         end
         OP_BGTZ: begin
            take = !zero && !neg;
         end
         OP_REGIMM: begin
            case (s1_rt_ff)
               RI_BLTZ: begin
                  take = neg;
               end
               RI_BGEZ: begin
                  take = !neg;
               end
               RI_BLTZAL: begin
                  take = neg;
                  wen  = 1'b1;
                  widx = LINK_REG;
                  wval = link;
               end
               RI_BGEZAL: begin
                  take = !neg;
                  wen  = 1'b1;
                  widx = LINK_REG;
                  wval = link;
               end
               default: begin
                  status = ST_UNK;
               end
            endcase
         end
         OP_LB, OP_LBU, OP_LH, OP_LHU, OP_LW, OP_LWL, OP_LWR: begin
            if (acc_ok) begin
               wen     = 1'b1;
               is_load = 1'b1;
            end else begin
               status = ST_ADDR;
            end
         end
         OP_SB, OP_SH, OP_SW: begin
            if (acc_ok) begin
               is_store = 1'b1;
            end else begin
               status = ST_ADDR;
            end
         end
         default: begin
            status = ST_UNK;
         end
      endcase
      if (wen && (widx == '0)) begin
         wen = 1'b0;
      end
      if (!wen) begin
         widx = '0;
         wval = '0;
      end
   end

   assign npc = take ? btarget : npc_seq;

   // Byte j of an access sits in bank (start + j) mod 4; a store sends its bytes high first.
   for (genvar b = 0; b < BANKS; b++) begin : g_lane
      logic [1:0] lane_j;
      logic [1:0] src_byte;

      assign lane_j       = 2'(b) - acc_r;
      assign src_byte     = 2'(acc_n - 3'd1 - {1'b0, lane_j});
      assign ex_row[b]    = row_base + ((2'(b) < acc_r) ? ROW_W'(1) : ROW_W'(0));
      assign ex_st_en[b]  = is_store && ({1'b0, lane_j} < acc_n);
      assign ex_st_dat[b] = t_val[{src_byte, 3'b000} +: 8];
      assign dm_rd_row[b] = s1_go ? ex_row[b] : s2_row_ff[b];
      assign ld_byte[b]   = dm_rd[s2_r_ff + 2'(b)];
   end

   assign dm_wr_en = s2_go ? s2_st_en_ff : '0;

   // Write-back stage: load data is aligned and merged here.
   assign ld_word = {ld_byte[0], ld_byte[1], ld_byte[2], ld_byte[3]};

   always_comb begin
      case (s2_op_ff)
         OP_LB:   ld_val = {{24{ld_word[31]}}, ld_word[31:24]};
         OP_LBU:  ld_val = {24'h000000, ld_word[31:24]};
         OP_LH:   ld_val = {{16{ld_word[31]}}, ld_word[31:16]};
         OP_LHU:  ld_val = {16'h0000, ld_word[31:16]};
         OP_LWL:  ld_val = (ld_word & (32'hFFFF_FFFF << {s2_k_ff, 3'b000})) |
                           (s2_t_ff & ~(32'hFFFF_FFFF << {s2_k_ff, 3'b000}));
         OP_LWR:  ld_val = (ld_word >> {2'd3 - s2_k_ff, 3'b000}) |
                           (s2_t_ff & (32'hFFFF_FFFF << {3'({1'b0, s2_k_ff} + 3'd1), 3'b000}));
         default: ld_val = ld_word;
      endcase
   end

   assign wb_val = (s2_load_ff && s2_wen_ff) ? ld_val : s2_wval_ff;

   assign rf_wr.en   = s2_go && s2_wen_ff;
   assign rf_wr.idx  = s2_widx_ff;
   assign rf_wr.data = wb_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (req_acc) begin
            s1_vld_ff <= 1'b1;
         end else if (s1_go) begin
            s1_vld_ff <= 1'b0;
         end
         if (s1_go) begin
            s2_vld_ff <= 1'b1;
         end else if (s2_go) begin
            s2_vld_ff <= 1'b0;
         end
         if (s2_go) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_op_ff  <= req_bus.func;
         s1_rs_ff  <= req_bus.base_reg;
         s1_rt_ff  <= req_bus.target_reg;
         s1_imm_ff <= req_bus.immediate;
         s1_seb_ff <= sext16(req_bus.immediate) - data_base_ff;
      end
      if (s1_go) begin
         s2_npc_ff    <= npc;
         s2_status_ff <= status;
         s2_wen_ff    <= wen;
         s2_widx_ff   <= widx;
         s2_wval_ff   <= wval;
         s2_load_ff   <= is_load;
         s2_op_ff     <= s1_op_ff;
         s2_k_ff      <= k;
         s2_r_ff      <= acc_r;
         s2_t_ff      <= t_val;
         s2_st_en_ff  <= ex_st_en;
         s2_row_ff    <= ex_row;
         s2_st_dat_ff <= ex_st_dat;
      end
      if (s2_go) begin
         out_npc_ff    <= s2_npc_ff;
         out_status_ff <= s2_status_ff;
         out_wen_ff    <= s2_wen_ff;
         out_widx_ff   <= s2_widx_ff;
         out_wval_ff   <= wb_val;
      end
   end

   assign rsp_bus.valid        = out_vld_ff;
   assign rsp_bus.next_pc      = out_npc_ff;
   assign rsp_bus.status       = out_status_ff;
   assign rsp_bus.write_enable = out_wen_ff;
   assign rsp_bus.write_index  = out_widx_ff;
   assign rsp_bus.write_value  = out_wval_ff;

   a_write_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.write_enable) |->
         ((rsp_bus.status == ST_OK) && (rsp_bus.write_index != '0)))
      else $error("Register write reported with a failing status or for register zero.");

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      dm_busy |-> !req_bus.ready)
      else $error("Instruction transfer allowed while the data memory is being cleared.");

   a_load_use_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && hazard) |=> (s1_vld_ff && $stable(s1_op_ff) && $stable(s1_rs_ff)))
      else $error("Instruction waiting on a load result left the execute stage.");

endmodule

[rtl/mie_regfile.sv]
module mie_regfile
   import mie_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [REG_IDX_W-1:0] rd_idx_a,
   input  logic [REG_IDX_W-1:0] rd_idx_b,
   output logic [XLEN-1:0]      rd_data_a,
   output logic [XLEN-1:0]      rd_data_b,
   input  mie_rf_wr_type        wr
);

   logic [XLEN-1:0]      regs_ff [REG_COUNT];
   logic [REG_COUNT-1:0] vld_ff;
   logic [XLEN-1:0]      q_a_ff;
   logic [XLEN-1:0]      q_b_ff;
   logic [XLEN-1:0]      wdata_ff;
   logic                 vld_a_ff;
   logic                 vld_b_ff;
   logic                 hit_a_ff;
   logic                 hit_b_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         regs_ff[wr.idx] <= wr.data;
      end
      q_a_ff   <= regs_ff[rd_idx_a];
      q_b_ff   <= regs_ff[rd_idx_b];
      wdata_ff <= wr.data;
   end

   // Entries never written since reset read as zero; a write at the read edge wins.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
         hit_a_ff <= 1'b0;
         hit_b_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            vld_ff[wr.idx] <= 1'b1;
         end
         vld_a_ff <= vld_ff[rd_idx_a];
         vld_b_ff <= vld_ff[rd_idx_b];
         hit_a_ff <= wr.en && (wr.idx == rd_idx_a);
         hit_b_ff <= wr.en && (wr.idx == rd_idx_b);
      end
   end

   assign rd_data_a = hit_a_ff ? wdata_ff : (vld_a_ff ? q_a_ff : '0);
   assign rd_data_b = hit_b_ff ? wdata_ff : (vld_b_ff ? q_b_ff : '0);

endmodule

[rtl/mie_dmem.sv]
module mie_dmem
   import mie_pkg::*;
#(
   parameter int unsigned DATA_BYTES = DATA_BYTES_DEF,
   localparam int unsigned ROWS = (DATA_BYTES + BANKS - 1) / BANKS,
   localparam int unsigned ROW_W = $clog2(ROWS)
)(
   input  logic             clock,
   input  logic             reset,
   output logic             busy,
   input  logic [ROW_W-1:0] rd_row  [BANKS],
   output logic [7:0]       rd_data [BANKS],
   input  logic [BANKS-1:0] wr_en,
   input  logic [ROW_W-1:0] wr_row  [BANKS],
   input  logic [7:0]       wr_data [BANKS]
);

   logic             busy_ff;
   logic [ROW_W-1:0] clr_row_ff;

   // After reset every row of every bank is written with zero, one row per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b1;
         clr_row_ff <= '0;
      end else if (busy_ff) begin
         clr_row_ff <= clr_row_ff + ROW_W'(1);
         if (clr_row_ff == ROW_W'(ROWS - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign busy = busy_ff;

   for (genvar b = 0; b < BANKS; b++) begin : g_bank
      logic [7:0]       bank_ff [ROWS];
      logic [7:0]       q_ff;
      logic [7:0]       wdat_ff;
      logic             hit_ff;
      logic             we;
      logic [ROW_W-1:0] wa;
      logic [7:0]       wd;

      assign we = busy_ff || wr_en[b];
      assign wa = busy_ff ? clr_row_ff : wr_row[b];
      assign wd = busy_ff ? 8'h00 : wr_data[b];

      always_ff @(posedge clock) begin
         if (we) begin
            bank_ff[wa] <= wd;
         end
         q_ff    <= bank_ff[rd_row[b]];
         wdat_ff <= wd;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            hit_ff <= 1'b0;
         end else begin
            hit_ff <= we && (wa == rd_row[b]);
         end
      end

      assign rd_data[b] = hit_ff ? wdat_ff : q_ff;
   end

endmodule
